// ----- hw/rtl/tun_pkg.sv -----
package tun_pkg;

    localparam int COORD_WIDTH = 16;
    localparam int FRAC_BITS = 15;
    localparam int FIELD_WIDTH = 16;
    localparam int OUT_WIDTH = 16;

endpackage

// ----- hw/rtl/tun_if.sv -----
interface tun_in_if;

    logic valid;
    logic ready;
    logic signed [tun_pkg::FIELD_WIDTH-1:0] origin_x;
    logic signed [tun_pkg::FIELD_WIDTH-1:0] origin_y;
    logic signed [tun_pkg::FIELD_WIDTH-1:0] origin_z;
    logic signed [tun_pkg::FIELD_WIDTH-1:0] first_x;
    logic signed [tun_pkg::FIELD_WIDTH-1:0] first_y;
    logic signed [tun_pkg::FIELD_WIDTH-1:0] first_z;
    logic signed [tun_pkg::FIELD_WIDTH-1:0] second_x;
    logic signed [tun_pkg::FIELD_WIDTH-1:0] second_y;
    logic signed [tun_pkg::FIELD_WIDTH-1:0] second_z;

    modport source (
        output valid, origin_x, origin_y, origin_z, first_x, first_y, first_z,
               second_x, second_y, second_z,
        input  ready
    );

    modport sink (
        input  valid, origin_x, origin_y, origin_z, first_x, first_y, first_z,
               second_x, second_y, second_z,
        output ready
    );

endinterface

interface tun_out_if;

    logic valid;
    logic ready;
    logic signed [tun_pkg::OUT_WIDTH-1:0] normal_x;
    logic signed [tun_pkg::OUT_WIDTH-1:0] normal_y;
    logic signed [tun_pkg::OUT_WIDTH-1:0] normal_z;
    logic degenerate;

    modport source (
        output valid, normal_x, normal_y, normal_z, degenerate,
        input  ready
    );

    modport sink (
        input  valid, normal_x, normal_y, normal_z, degenerate,
        output ready
    );

endinterface

// ----- hw/rtl/triangle_unit_normal.sv -----
// Unit face normal of one triangle per transfer: edges from the origin vertex, their exact
// cross product, and each component divided by the length in signed Q1.(FRAC_BITS), rounded
// to nearest and saturated; a zero cross product gives zeros and raises degenerate. The
// pipeline takes one transfer per cycle when no stage stalls, and finds the exact rounded
// quotient one result bit per stage. Each stage stalls only when it is full and the stage
// after it cannot take its contents.
module triangle_unit_normal #(
    parameter int COORD_WIDTH = tun_pkg::COORD_WIDTH,
    parameter int FRAC_BITS = tun_pkg::FRAC_BITS
) (
    input logic clk,
    input logic rst_n,
    tun_in_if.sink triangle,
    tun_out_if.source normal
);

    localparam int W = COORD_WIDTH;
    localparam int F = FRAC_BITS;
    localparam int EW = W + 1;
    localparam int PW = 2 * EW;
    localparam int CW = PW + 1;
    localparam int MW = 2 * W + 2;
    localparam int H = MW / 2;
    localparam int SQW = 2 * MW;
    localparam int SW = SQW + 2;
    localparam int RW = SW + 2 * F + 6;
    localparam int QW = F + 1;
    localparam int OW = tun_pkg::OUT_WIDTH;
    localparam int POS_MAX = (F >= OW - 1) ? (1 << (OW - 1)) - 1 : (1 << F) - 1;
    localparam int NEG_MAG = (F >= OW - 1) ? (1 << (OW - 1)) : (1 << F);
    localparam int SRCH0 = 6;
    localparam int N = F + 8;

    logic [N-1:0] v_reg;
    logic [N:0] rdy;

    assign rdy[N] = normal.ready;
    for (genvar k = 0; k < N; k++) begin : g_rdy
        assign rdy[k] = !v_reg[k] || rdy[k+1];
    end
    assign triangle.ready = rdy[0];

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            v_reg <= '0;
        end
        else begin
            if (rdy[0]) begin
                v_reg[0] <= triangle.valid;
            end
            for (int k = 1; k < N; k++) begin
                if (rdy[k]) begin
                    v_reg[k] <= v_reg[k-1];
                end
            end
        end
    end

    function automatic logic signed [EW-1:0] edge_of(
        input logic [OW-1:0] a,
        input logic [OW-1:0] o
    );
        logic signed [W-1:0] sa;
        logic signed [W-1:0] so;
        sa = W'(a);
        so = W'(o);
        edge_of = EW'(sa) - EW'(so);
    endfunction

    // Stage 0: edge vectors.
    logic signed [EW-1:0] e1_reg [3];
    logic signed [EW-1:0] e2_reg [3];

    always_ff @(posedge clk) begin
        if (rdy[0]) begin
            e1_reg[0] <= edge_of(triangle.first_x, triangle.origin_x);
            e1_reg[1] <= edge_of(triangle.first_y, triangle.origin_y);
            e1_reg[2] <= edge_of(triangle.first_z, triangle.origin_z);
            e2_reg[0] <= edge_of(triangle.second_x, triangle.origin_x);
            e2_reg[1] <= edge_of(triangle.second_y, triangle.origin_y);
            e2_reg[2] <= edge_of(triangle.second_z, triangle.origin_z);
        end
    end

    // Stage 1: the six products of the cross product.
    logic signed [PW-1:0] pa_reg [3];
    logic signed [PW-1:0] pb_reg [3];

    always_ff @(posedge clk) begin
        if (rdy[1]) begin
            for (int c = 0; c < 3; c++) begin
                pa_reg[c] <= e1_reg[(c + 1) % 3] * e2_reg[(c + 2) % 3];
                pb_reg[c] <= e1_reg[(c + 2) % 3] * e2_reg[(c + 1) % 3];
            end
        end
    end

    // Stage 2: components, magnitudes and signs.
    logic signed [CW-1:0] cr_next [3];
    logic [MW-1:0] m_reg [3];
    logic [2:0] neg2_reg;
    logic dg2_reg;

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            cr_next[c] = CW'(pa_reg[c]) - CW'(pb_reg[c]);
        end
    end

    always_ff @(posedge clk) begin
        if (rdy[2]) begin
            for (int c = 0; c < 3; c++) begin
                neg2_reg[c] <= cr_next[c][CW-1];
                m_reg[c] <= cr_next[c][CW-1] ? MW'(-cr_next[c]) : MW'(cr_next[c]);
            end
            dg2_reg <= (cr_next[0] == '0) && (cr_next[1] == '0) && (cr_next[2] == '0);
        end
    end

    // Stage 3: partial products of the squares.
    logic [2*H-1:0] hh_reg [3];
    logic [2*H-1:0] hl_reg [3];
    logic [2*H-1:0] ll_reg [3];
    logic [2:0] neg3_reg;
    logic dg3_reg;

    always_ff @(posedge clk) begin
        if (rdy[3]) begin
            for (int c = 0; c < 3; c++) begin
                hh_reg[c] <= m_reg[c][MW-1:H] * m_reg[c][MW-1:H];
                hl_reg[c] <= m_reg[c][MW-1:H] * m_reg[c][H-1:0];
                ll_reg[c] <= m_reg[c][H-1:0] * m_reg[c][H-1:0];
            end
            neg3_reg <= neg2_reg;
            dg3_reg <= dg2_reg;
        end
    end

    // Stage 4: squared magnitudes.
    logic [SQW-1:0] msq_reg [3];
    logic [2:0] neg4_reg;
    logic dg4_reg;

    always_ff @(posedge clk) begin
        if (rdy[4]) begin
            for (int c = 0; c < 3; c++) begin
                msq_reg[c] <= (SQW'(hh_reg[c]) << (2 * H)) + (SQW'(hl_reg[c]) << (H + 1))
                    + SQW'(ll_reg[c]);
            end
            neg4_reg <= neg3_reg;
            dg4_reg <= dg3_reg;
        end
    end

    // Stage 5 seeds the search; stage 6 + k settles quotient bit F - k.
    logic [SW-1:0] sum_next;
    logic signed [RW-1:0] sr_r_reg [F+2][3];
    logic signed [RW-1:0] sr_t_reg [F+2][3];
    logic [QW-1:0] sr_q_reg [F+2][3];
    logic [SW-1:0] sr_s_reg [F+2];
    logic [2:0] sr_neg_reg [F+2];
    logic sr_dg_reg [F+2];

    assign sum_next = SW'(msq_reg[0]) + SW'(msq_reg[1]) + SW'(msq_reg[2]);

    always_ff @(posedge clk) begin
        if (rdy[5]) begin
            for (int c = 0; c < 3; c++) begin
                sr_r_reg[0][c] <= (RW'(msq_reg[c]) << (2 * F + 2)) - RW'(sum_next);
                sr_t_reg[0][c] <= RW'(0) - RW'(sum_next);
                sr_q_reg[0][c] <= '0;
            end
            sr_s_reg[0] <= sum_next;
            sr_neg_reg[0] <= neg4_reg;
            sr_dg_reg[0] <= dg4_reg;
        end
    end

    for (genvar k = 0; k <= F; k++) begin : g_srch
        localparam int J = F - k;
        logic signed [RW-1:0] r_next [3];

        always_comb begin
            for (int c = 0; c < 3; c++) begin
                r_next[c] = sr_r_reg[k][c] - (sr_t_reg[k][c] <<< (J + 2))
                    - (RW'(sr_s_reg[k]) << (2 * J + 2));
            end
        end

        always_ff @(posedge clk) begin
            if (rdy[SRCH0 + k]) begin
                for (int c = 0; c < 3; c++) begin
                    if (!r_next[c][RW-1]) begin
                        sr_r_reg[k+1][c] <= r_next[c];
                        sr_t_reg[k+1][c] <= sr_t_reg[k][c] + (RW'(sr_s_reg[k]) << (J + 1));
                        sr_q_reg[k+1][c] <= sr_q_reg[k][c] | (QW'(1) << J);
                    end
                    else begin
                        sr_r_reg[k+1][c] <= sr_r_reg[k][c];
                        sr_t_reg[k+1][c] <= sr_t_reg[k][c];
                        sr_q_reg[k+1][c] <= sr_q_reg[k][c];
                    end
                end
                sr_s_reg[k+1] <= sr_s_reg[k];
                sr_neg_reg[k+1] <= sr_neg_reg[k];
                sr_dg_reg[k+1] <= sr_dg_reg[k];
            end
        end
    end

    // Output stage: sign, saturation and the degenerate case.
    logic [OW-1:0] nv_next [3];
    logic [OW-1:0] nv_reg [3];
    logic dg_reg;

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            if (sr_dg_reg[F+1]) begin
                nv_next[c] = '0;
            end
            else if (sr_neg_reg[F+1][c]) begin
                nv_next[c] = OW'(0) - ((sr_q_reg[F+1][c] > QW'(NEG_MAG)) ? OW'(NEG_MAG)
                    : OW'(sr_q_reg[F+1][c]));
            end
            else begin
                nv_next[c] = (sr_q_reg[F+1][c] > QW'(POS_MAX)) ? OW'(POS_MAX)
                    : OW'(sr_q_reg[F+1][c]);
            end
        end
    end

    always_ff @(posedge clk) begin
        if (rdy[N-1]) begin
            for (int c = 0; c < 3; c++) begin
                nv_reg[c] <= nv_next[c];
            end
            dg_reg <= sr_dg_reg[F+1];
        end
    end

    assign normal.valid = v_reg[N-1];
    assign normal.normal_x = nv_reg[0];
    assign normal.normal_y = nv_reg[1];
    assign normal.normal_z = nv_reg[2];
    assign normal.degenerate = dg_reg;

`ifndef SYNTHESIS
    assert property (@(posedge clk) disable iff (!rst_n)
        normal.valid && normal.degenerate |->
            normal.normal_x == '0 && normal.normal_y == '0 && normal.normal_z == '0)
        else $error("degenerate result with a nonzero normal");

    assert property (@(posedge clk) disable iff (!rst_n)
        normal.valid && !normal.degenerate |->
            normal.normal_x != '0 || normal.normal_y != '0 || normal.normal_z != '0)
        else $error("zero normal without the degenerate flag");

    assert property (@(posedge clk) disable iff (!rst_n)
        normal.valid |-> $signed(normal.normal_x) <= POS_MAX
            && $signed(normal.normal_y) <= POS_MAX && $signed(normal.normal_z) <= POS_MAX)
        else $error("normal component above the positive limit");

    assert property (@(posedge clk) disable iff (!rst_n)
        normal.valid && !normal.ready |=> normal.valid && $stable(normal.normal_x)
            && $stable(normal.normal_y) && $stable(normal.normal_z)
            && $stable(normal.degenerate))
        else $error("stall did not hold the output transfer");
`endif

endmodule

// ----- tb/testbench.sv -----
module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_CYCLES = 40;
    localparam int RANDOM_ITEMS = 100;

    typedef logic signed [tun_pkg::FIELD_WIDTH-1:0] coord_t;
    typedef logic [159:0] wide_t;

    typedef struct packed {
        coord_t origin_x;
        coord_t origin_y;
        coord_t origin_z;
        coord_t first_x;
        coord_t first_y;
        coord_t first_z;
        coord_t second_x;
        coord_t second_y;
        coord_t second_z;
    } triangle_t;

    typedef struct packed {
        logic signed [tun_pkg::OUT_WIDTH-1:0] normal_x;
        logic signed [tun_pkg::OUT_WIDTH-1:0] normal_y;
        logic signed [tun_pkg::OUT_WIDTH-1:0] normal_z;
        logic degenerate;
    } normal_t;

    logic clk;
    logic rst_n;
    int cycle_count;
    int error_count;
    int send_idle_pct;
    int stall_pct;
    normal_t expected_normals[$];

    tun_in_if triangle_if ();
    tun_out_if normal_if ();

    triangle_unit_normal i_dut (
        .clk(clk),
        .rst_n(rst_n),
        .triangle(triangle_if),
        .normal(normal_if)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #2 clk = ~clk;
        end
    end

    function automatic longint coord_value(coord_t raw);
        return longint'(raw);
    endfunction

    function automatic longint abs_value(longint v);
        return (v < 0) ? -v : v;
    endfunction

    // Largest q in [0, 2^FRAC_BITS] with (2q-1)^2 * len2 <= 4 * mag^2 * 2^(2*FRAC_BITS).
    function automatic longint rounded_quotient(longint mag, wide_t len2);
        wide_t limit;
        wide_t lhs;
        wide_t odd;
        longint lo;
        longint hi;
        longint mid;
        limit = (wide_t'(mag) * wide_t'(mag)) << (2 * tun_pkg::FRAC_BITS + 2);
        lo = 0;
        hi = longint'(1) << tun_pkg::FRAC_BITS;
        while (lo < hi)
        begin
            mid = lo + (hi - lo + 1) / 2;
            odd = wide_t'(2 * mid - 1);
            lhs = odd * odd * len2;
            if (lhs <= limit)
                lo = mid;
            else
                hi = mid - 1;
        end
        return lo;
    endfunction

    function automatic logic signed [tun_pkg::OUT_WIDTH-1:0] unit_component(longint c,
                                                                             wide_t len2);
        longint q;
        longint v;
        q = rounded_quotient(abs_value(c), len2);
        if (c < 0)
        begin
            v = -q;
            if (v < -32768)
                v = -32768;
        end
        else
        begin
            v = q;
            if (v > (longint'(1) << tun_pkg::FRAC_BITS) - 1)
                v = (longint'(1) << tun_pkg::FRAC_BITS) - 1;
            if (v > 32767)
                v = 32767;
        end
        return v[tun_pkg::OUT_WIDTH-1:0];
    endfunction

    function automatic normal_t predict_normal(triangle_t t);
        longint ax;
        longint ay;
        longint az;
        longint bx;
        longint by;
        longint bz;
        longint cx;
        longint cy;
        longint cz;
        wide_t len2;
        normal_t n;
        ax = coord_value(t.first_x) - coord_value(t.origin_x);
        ay = coord_value(t.first_y) - coord_value(t.origin_y);
        az = coord_value(t.first_z) - coord_value(t.origin_z);
        bx = coord_value(t.second_x) - coord_value(t.origin_x);
        by = coord_value(t.second_y) - coord_value(t.origin_y);
        bz = coord_value(t.second_z) - coord_value(t.origin_z);
        cx = ay * bz - az * by;
        cy = az * bx - ax * bz;
        cz = ax * by - ay * bx;
        n = '0;
        if (cx == 0 && cy == 0 && cz == 0)
        begin
            n.degenerate = 1'b1;
            return n;
        end
        len2 = wide_t'(abs_value(cx)) * wide_t'(abs_value(cx))
             + wide_t'(abs_value(cy)) * wide_t'(abs_value(cy))
             + wide_t'(abs_value(cz)) * wide_t'(abs_value(cz));
        n.normal_x = unit_component(cx, len2);
        n.normal_y = unit_component(cy, len2);
        n.normal_z = unit_component(cz, len2);
        return n;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch at cycle %0d: %s got %0d expected %0d", cycle_count, what, got, want);
        error_count++;
    endtask

    // The sender leaves valid as it is after a transfer, so that the next call assigns it once.
    task automatic send_triangle(triangle_t t);
        while ($urandom_range(99) < send_idle_pct)
        begin
            triangle_if.valid <= 1'b0;
            @(negedge clk);
        end
        triangle_if.valid <= 1'b1;
        triangle_if.origin_x <= t.origin_x;
        triangle_if.origin_y <= t.origin_y;
        triangle_if.origin_z <= t.origin_z;
        triangle_if.first_x <= t.first_x;
        triangle_if.first_y <= t.first_y;
        triangle_if.first_z <= t.first_z;
        triangle_if.second_x <= t.second_x;
        triangle_if.second_y <= t.second_y;
        triangle_if.second_z <= t.second_z;
        forever
        begin
            @(posedge clk);
            if (triangle_if.ready)
                break;
        end
        expected_normals.push_back(predict_normal(t));
        @(negedge clk);
    endtask

    task automatic wait_for_normals();
        triangle_if.valid <= 1'b0;
        while (expected_normals.size() != 0)
            @(negedge clk);
    endtask

    function automatic triangle_t make_triangle(longint ox, longint oy, longint oz,
                                                longint ax, longint ay, longint az,
                                                longint bx, longint by, longint bz);
        triangle_t t;
        t.origin_x = ox[15:0];
        t.origin_y = oy[15:0];
        t.origin_z = oz[15:0];
        t.first_x = ax[15:0];
        t.first_y = ay[15:0];
        t.first_z = az[15:0];
        t.second_x = bx[15:0];
        t.second_y = by[15:0];
        t.second_z = bz[15:0];
        return t;
    endfunction

    function automatic triangle_t random_triangle();
        triangle_t t;
        wide_t bits;
        longint ox;
        longint oy;
        longint oz;
        longint dx;
        longint dy;
        longint dz;
        longint k;
        case ($urandom_range(3))
            0:
            begin
                bits = {$urandom, $urandom, $urandom, $urandom, $urandom};
                t = bits[$bits(triangle_t)-1:0];
            end
            1:
            begin
                ox = $signed($urandom_range(65535) - 32768) / 2;
                oy = $signed($urandom_range(65535) - 32768) / 2;
                oz = $signed($urandom_range(65535) - 32768) / 2;
                t = make_triangle(ox, oy, oz,
                    ox + $urandom_range(64) - 32, oy + $urandom_range(64) - 32,
                    oz + $urandom_range(64) - 32,
                    ox + $urandom_range(64) - 32, oy + $urandom_range(64) - 32,
                    oz + $urandom_range(64) - 32);
            end
            2:
            begin
                ox = $urandom_range(2000) - 1000;
                oy = $urandom_range(2000) - 1000;
                oz = $urandom_range(2000) - 1000;
                dx = $urandom_range(200) - 100;
                dy = $urandom_range(200) - 100;
                dz = $urandom_range(200) - 100;
                k = $urandom_range(20) - 10;
                t = make_triangle(ox, oy, oz, ox + dx, oy + dy, oz + dz,
                    ox + k * dx, oy + k * dy, oz + k * dz);
            end
            default:
            begin
                ox = $urandom_range(65535) - 32768;
                oy = $urandom_range(65535) - 32768;
                oz = $urandom_range(65535) - 32768;
                t = make_triangle(ox, oy, oz,
                    $urandom_range(65535) - 32768, oy, oz,
                    ox, $urandom_range(65535) - 32768, oz);
            end
        endcase
        return t;
    endfunction

    task automatic test_directed();
        send_idle_pct = 0;
        stall_pct = 0;
        send_triangle(make_triangle(0, 0, 0, 0, 0, 0, 0, 0, 0));
        send_triangle(make_triangle(5, -7, 9, 5, -7, 9, 1, 2, 3));
        send_triangle(make_triangle(0, 0, 0, 1, 0, 0, 0, 1, 0));
        send_triangle(make_triangle(0, 0, 0, 0, 1, 0, 1, 0, 0));
        send_triangle(make_triangle(0, 0, 0, 0, 1, 0, 0, 0, 1));
        send_triangle(make_triangle(0, 0, 0, 0, 0, 1, 0, 1, 0));
        send_triangle(make_triangle(0, 0, 0, 0, 0, 1, 1, 0, 0));
        send_triangle(make_triangle(0, 0, 0, 1, 0, 0, 0, 0, 1));
        send_triangle(make_triangle(-32768, -32768, -32768, 32767, -32768, -32768,
            -32768, 32767, -32768));
        send_triangle(make_triangle(32767, 32767, 32767, -32768, 32767, 32767,
            32767, 32767, -32768));
        send_triangle(make_triangle(-32768, 32767, -32768, 32767, -32768, 32767,
            32767, 32767, -32768));
        send_triangle(make_triangle(0, 0, 0, 1, 1, 1, 2, 2, 2));
        send_triangle(make_triangle(0, 0, 0, 1, 0, 0, 1, 1, 1));
        send_triangle(make_triangle(0, 0, 0, 3, 0, 0, 0, 4, 0));
        send_triangle(make_triangle(-1, -1, -1, 32767, 32767, 32767, -32768, -32768, -32768));
        send_triangle(make_triangle(0, 0, 0, 32767, 1, 0, 1, 32767, 0));
        wait_for_normals();
    endtask

    task automatic test_random(int sender_pct, int receiver_pct);
        send_idle_pct = sender_pct;
        stall_pct = receiver_pct;
        repeat (RANDOM_ITEMS)
            send_triangle(random_triangle());
        wait_for_normals();
    endtask

    task automatic test_pause_until_drained();
        send_idle_pct = 0;
        stall_pct = 30;
        repeat (10)
            send_triangle(random_triangle());
        wait_for_normals();
        repeat (10)
            send_triangle(random_triangle());
        wait_for_normals();
    endtask

    always @(negedge clk)
    begin
        if (rst_n)
            normal_if.ready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge clk)
    begin
        normal_t got;
        normal_t want;
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("testbench NOT OK");
            $finish;
        end
        if (rst_n && normal_if.valid && normal_if.ready)
        begin
            got.normal_x = normal_if.normal_x;
            got.normal_y = normal_if.normal_y;
            got.normal_z = normal_if.normal_z;
            got.degenerate = normal_if.degenerate;
            if (expected_normals.size() == 0)
            begin
                report_mismatch("unexpected transfer", 1, 0);
            end
            else
            begin
                want = expected_normals.pop_front();
                if (got.normal_x !== want.normal_x)
                    report_mismatch("normal_x", got.normal_x, want.normal_x);
                if (got.normal_y !== want.normal_y)
                    report_mismatch("normal_y", got.normal_y, want.normal_y);
                if (got.normal_z !== want.normal_z)
                    report_mismatch("normal_z", got.normal_z, want.normal_z);
                if (got.degenerate !== want.degenerate)
                    report_mismatch("degenerate", got.degenerate, want.degenerate);
            end
        end
    end

    initial
    begin
        cycle_count = 0;
        error_count = 0;
        send_idle_pct = 0;
        stall_pct = 0;
        rst_n = 1'b0;
        normal_if.ready = 1'b0;
        triangle_if.valid = 1'b0;
        triangle_if.origin_x = '0;
        triangle_if.origin_y = '0;
        triangle_if.origin_z = '0;
        triangle_if.first_x = '0;
        triangle_if.first_y = '0;
        triangle_if.first_z = '0;
        triangle_if.second_x = '0;
        triangle_if.second_y = '0;
        triangle_if.second_z = '0;
        repeat (4)
            @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        test_directed();
        test_random(0, 0);
        test_random(77, 0);
        test_random(0, 77);
        test_random(17, 17);
        test_pause_until_drained();
        repeat (DRAIN_CYCLES)
            @(negedge clk);
        if (error_count == 0 && expected_normals.size() == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end

endmodule
